// File: rtl/core/fwdf_pkg.sv
// fwdf_pkg: shared constants and types for the fixed-width decimal formatter
// no dependencies; used by the digit cell, the digit chain and the top level
package fwdf_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int VALUE_W    = 32;
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BITCNT_W   = $clog2(VALUE_W);
    localparam int COORD_W    = 8;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;

    localparam logic       CMD_UNSIGNED = 1'b0;
    localparam logic       CMD_SIGNED   = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic clear;
        logic shift;
    } bcd_ctrl_t;

    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// File: rtl/core/fwdf_bcd_cell.sv
// fwdf_bcd_cell: one decimal digit of the shift-and-add-3 conversion chain
// depends on fwdf_pkg
module fwdf_bcd_cell
    import fwdf_pkg::*;
(
    input  logic      clk,
    input  bcd_ctrl_t ctrl,
    input  logic      bit_in,
    output logic      bit_out,
    output digit_t    digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    always_comb
    begin
        adj = (digit_reg >= digit_t'(5)) ? digit_reg + digit_t'(3) : digit_reg;
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

endmodule

// File: rtl/core/fwdf_bcd_chain.sv
// fwdf_bcd_chain: row of digit cells, least significant digit first
// depends on fwdf_pkg and fwdf_bcd_cell
module fwdf_bcd_chain
    import fwdf_pkg::*;
(
    input  logic                       clk,
    input  bcd_ctrl_t                  ctrl,
    input  logic                       bit_in,
    output digit_t [MAX_DIGITS-1:0]    digits
);

    logic [MAX_DIGITS-1:0] carry;

    assign carry[0] = bit_in;

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        if (i < MAX_DIGITS - 1)
        begin : g_mid
            fwdf_bcd_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .bit_in  (carry[i]),
                .bit_out (carry[i+1]),
                .digit   (digits[i])
            );
        end
        else
        begin : g_top
            fwdf_bcd_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .bit_in  (carry[i]),
                .bit_out (),
                .digit   (digits[i])
            );
        end
    end

endmodule

// File: rtl/core/fixed_width_decimal_formatter_core.sv
// fixed_width_decimal_formatter_core: formats a 32-bit value as fixed-width ascii digits
// depends on fwdf_pkg and fwdf_bcd_chain
// the first character is offered once the magnitude has been shifted through the digit chain
// a new input is taken only in idle, after the last character of the previous item is loaded;
//   the chain shifts one bit a cycle; unsigned with no digits: nothing is emitted, the block stays idle
// reset: rst_n clears the control state and the output valid; digit cells need no reset
module fixed_width_decimal_formatter_core
    import fwdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // value[31:0], digit_count, start_column, text_line
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_line, out_column, character, zero pad
    output logic        m_axis_tlast    // last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [DCNT_W-1:0]   left_reg, left_next;
    logic                sign_pend_reg, sign_pend_next;
    logic                neg_reg, neg_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  line_reg, line_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    logic [COORD_W-1:0]  out_line_reg, out_line_next;
    logic [COORD_W-1:0]  out_col_reg, out_col_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;

    logic                in_fire;
    logic                out_load;
    logic                in_cmd;
    logic [VALUE_W-1:0]  in_value;
    logic [3:0]          in_count;
    logic [DCNT_W-1:0]   sat_count;
    logic                in_neg;
    logic [DIDX_W-1:0]   digit_idx;
    logic                emit_last;
    bcd_ctrl_t           chain_ctrl;
    digit_t [MAX_DIGITS-1:0] digits;

    assign in_cmd    = s_axis_tuser;
    assign in_value  = s_axis_tdata[31:0];
    assign in_count  = s_axis_tdata[35:32];
    assign sat_count = (in_count > 4'(MAX_DIGITS)) ? DCNT_W'(MAX_DIGITS) : DCNT_W'(in_count);
    assign in_neg    = (in_cmd == CMD_SIGNED) && in_value[VALUE_W-1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    assign chain_ctrl.clear = in_fire;
    assign chain_ctrl.shift = (state_reg == ST_CONV);

    fwdf_bcd_chain u_chain (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .bit_in (mag_reg[VALUE_W-1]),
        .digits (digits)
    );

    assign digit_idx = DIDX_W'(left_reg - DCNT_W'(1));
    assign emit_last = sign_pend_reg ? (left_reg == '0) : (left_reg == DCNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        mag_next       = mag_reg;
        left_next      = left_reg;
        sign_pend_next = sign_pend_reg;
        neg_next       = neg_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_line_next  = out_line_reg;
        out_col_next   = out_col_reg;
        out_char_next  = out_char_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mag_next       = in_neg ? (~in_value + VALUE_W'(1)) : in_value;
                    left_next      = sat_count;
                    sign_pend_next = (in_cmd == CMD_SIGNED);
                    neg_next       = in_neg;
                    col_next       = s_axis_tdata[43:36];
                    line_next      = s_axis_tdata[51:44];
                    bit_cnt_next   = '0;
                    if ((in_cmd == CMD_SIGNED) || (sat_count != '0))
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
                if (bit_cnt_reg == BITCNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = emit_last;
                    out_line_next  = line_reg;
                    out_col_next   = col_reg;
                    col_next       = col_reg + COORD_W'(1);
                    if (sign_pend_reg)
                    begin
                        out_char_next  = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + CHAR_W'(digits[digit_idx]);
                        left_next     = left_reg - DCNT_W'(1);
                    end
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            left_reg      <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            left_reg      <= left_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        col_reg      <= col_next;
        line_reg     <= line_next;
        out_last_reg <= out_last_next;
        out_line_reg <= out_line_next;
        out_col_reg  <= out_col_next;
        out_char_reg <= out_char_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg, out_col_reg, out_line_reg};

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("output valid rose outside the emit phase");

    a_conv_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && bit_cnt_reg == BITCNT_W'(VALUE_W - 1)) |=>
        (state_reg == ST_EMIT))
        else $error("conversion did not end after the last magnitude bit");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> (state_reg == ST_IDLE))
        else $error("block did not return to idle after the last character");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= DCNT_W'(MAX_DIGITS))
        else $error("remaining digit count above the digit limit");

endmodule
